/* design/command_ring_reserve_commit_defines.svh */
// Assertion macros for the command ring reserve/commit block.
// Used by the top level; relies on clk and arst_n being in scope.
`ifndef COMMAND_RING_RESERVE_COMMIT_DEFINES_SVH
`define COMMAND_RING_RESERVE_COMMIT_DEFINES_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge out of reset
`define CRRC_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("crrc assertion failed");
// Antecedent this cycle implies consequent in the next cycle
`define CRRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crrc assertion failed");
`else
`define CRRC_ASSERT(label, cond)
`define CRRC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* design/crrc_pkg.sv */
// Shared types, codes and constants for the command ring reserve/commit block.
// No dependencies; imported by every module of the block.
package crrc_pkg;

	localparam int OFS_W       = 22;
	localparam int RING_BYTES  = 2097152;
	localparam int WORD_BYTES  = 4;
	localparam int SMALL_GRANT = WORD_BYTES * 5;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_DATA_W   = 48;
	localparam int OUT_DATA_W  = 72;

	// operation codes
	localparam logic [1:0] OP_RESERVE       = 2'd0;
	localparam logic [1:0] OP_COMMIT        = 2'd1;
	localparam logic [1:0] OP_COMMIT_STORED = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_FULL       = 3'd1;
	localparam logic [2:0] ST_BOUNCE     = 3'd2;
	localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
	localparam logic [2:0] ST_MISALIGNED = 3'd4;
	localparam logic [2:0] ST_PENDING    = 3'd5;
	localparam logic [2:0] ST_NONE       = 3'd6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RING_START      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RING_END        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVE_CAPABLE = 2'd2;

	typedef logic [OFS_W-1:0] ofs_t;

	typedef struct packed {
		ofs_t ring_start;
		ofs_t ring_end;
		logic reserve_capable;
	} cfg_t;

	typedef struct packed {
		logic [1:0] operation;
		ofs_t       byte_count;
		ofs_t       stop_offset;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		ofs_t       area_offset;
		logic       mark_write;
		ofs_t       mark_value;
		ofs_t       write_pointer;
	} result_t;

	// state update produced alongside each result
	typedef struct packed {
		ofs_t next_write;
		ofs_t pending_size;
	} ring_state_t;

endpackage

/* design/command_ring_reserve_commit.sv */
// Top level of the command ring reserve/commit block: stream ports,
// input and result registers, ring state. Depends on crrc_pkg, crrc_cfg,
// crrc_exec and command_ring_reserve_commit_defines.svh.
//
// Usage:
//   Items enter on the s_ channel (operation in s_tuser, count and consumer
//   stop offset in s_tdata); one result per item leaves on the m_ channel.
//   Ring bounds and the reserve capability are set through cfg_we/cfg_index/
//   cfg_data while the block is idle; writing ring_start also loads the
//   write pointer.
//   Path: an accepted item is evaluated from the input register and its
//   result is captured in the result register, which drives m_tvalid.
//   Throughput: one item per cycle while m_tready is high, set by the
//   single pass through the evaluation logic between the two registers.
//   Reset: the pipeline empties, the write pointer and the pending
//   reservation clear, ring_end returns to the full ring size.
//   Stalls: when m_tready is low the result register holds; the input
//   register still takes one more item, and s_tready drops once both are
//   full. Ring state advances only when an item moves into the result
//   register, so nothing is lost or repeated.
module command_ring_reserve_commit import crrc_pkg::*; #(
	parameter int RING_SIZE = RING_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  ofs_t                  cfg_data,
	// input items
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // byte_count[21:0], stop_offset[43:22], zero pad
	input  logic [1:0]            s_tuser,   // operation[1:0]
	// result items
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // status[2:0], area_offset[24:3], mark_write[25],
	                                         // mark_value[47:26], write_pointer[69:48], zero pad
);

`include "command_ring_reserve_commit_defines.svh"

	cfg_t        cfg;
	item_t       item_s1;
	logic        valid_s1;
	result_t     res_s2;
	logic        valid_s2;
	result_t     res;
	ring_state_t cur;
	ring_state_t nxt;
	ofs_t        next_write_q;
	ofs_t        pending_q;
	logic        adv_s1;

	crrc_cfg #(
		.RING_SIZE (RING_SIZE)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign cur.next_write   = next_write_q;
	assign cur.pending_size = pending_q;

	crrc_exec u_exec (
		.cfg  (cfg),
		.item (item_s1),
		.cur  (cur),
		.res  (res),
		.nxt  (nxt)
	);

	// handshake: stage 1 moves when the result register is free or draining
	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation   <= s_tuser;
			item_s1.byte_count  <= s_tdata[OFS_W-1:0];
			item_s1.stop_offset <= s_tdata[2*OFS_W-1:OFS_W];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	// ring state; a ring_start write reloads the pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_write_q <= '0;
			pending_q    <= '0;
		end else begin
			if (adv_s1) begin
				pending_q <= nxt.pending_size;
			end
			if (cfg_we && cfg_index == REG_RING_START) begin
				next_write_q <= cfg_data;
			end else if (adv_s1) begin
				next_write_q <= nxt.next_write;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.write_pointer, res_s2.mark_value, res_s2.mark_write,
		res_s2.area_offset, res_s2.status};

	// checks
	`CRRC_ASSERT(a_mark_only_on_ok, !(valid_s2 && res_s2.mark_write) || res_s2.status == ST_OK)
	`CRRC_ASSERT(a_pending_aligned, pending_q[1:0] == 2'b00)
	`CRRC_ASSERT_NEXT(a_commit_clears, adv_s1 && (item_s1.operation == OP_COMMIT || item_s1.operation == OP_COMMIT_STORED), pending_q == '0)
	`CRRC_ASSERT_NEXT(a_start_loads_ptr, cfg_we && cfg_index == REG_RING_START,
		next_write_q == $past(cfg_data))

endmodule

/* design/crrc_cfg.sv */
// Configuration register file: ring bounds and reserve capability.
// Depends on crrc_pkg.
module crrc_cfg import crrc_pkg::*; #(
	parameter int RING_SIZE = RING_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  ofs_t                 cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ring_start      <= '0;
			cfg_q.ring_end        <= OFS_W'(RING_SIZE);
			cfg_q.reserve_capable <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RING_START:      cfg_q.ring_start      <= cfg_data;
				REG_RING_END:        cfg_q.ring_end        <= cfg_data;
				REG_RESERVE_CAPABLE: cfg_q.reserve_capable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/crrc_exec.sv */
// Combinational reserve/commit evaluation for one item against ring state.
// Depends on crrc_pkg.
module crrc_exec import crrc_pkg::*; (
	input  cfg_t        cfg,
	input  item_t       item,
	input  ring_state_t cur,
	output result_t     res,
	output ring_state_t nxt
);

	always_comb begin
		logic [OFS_W:0]   end_sum;
		logic [OFS_W:0]   commit_sum;
		ofs_t             commit_bytes;
		ofs_t             span;
		ofs_t             wrapped;
		logic signed [OFS_W+2:0] room;
		logic             in_place;
		logic [2:0]       rsv_status;

		res            = '0;
		nxt            = cur;
		in_place       = 1'b0;
		rsv_status     = ST_OK;

		// reserve checks and space test
		span    = (cfg.ring_end >= cfg.ring_start) ? cfg.ring_end - cfg.ring_start : '0;
		end_sum = {1'b0, cur.next_write} + {1'b0, item.byte_count};
		room    = $signed({3'b000, cfg.ring_end}) - $signed({3'b000, cur.next_write})
			+ $signed({3'b000, item.stop_offset}) - $signed({3'b000, cfg.ring_start});

		if (item.byte_count > span) begin
			rsv_status = ST_TOO_LARGE;
		end else if (item.byte_count[1:0] != 2'b00) begin
			rsv_status = ST_MISALIGNED;
		end else if (cur.pending_size != '0) begin
			rsv_status = ST_PENDING;
		end else if (cur.next_write >= item.stop_offset) begin
			if (end_sum < {1'b0, cfg.ring_end} ||
				(end_sum == {1'b0, cfg.ring_end} && item.stop_offset > cfg.ring_start)) begin
				in_place = 1'b1;
			end else if (room <= $signed({3'b000, item.byte_count})) begin
				rsv_status = ST_FULL;
			end else begin
				rsv_status = ST_BOUNCE;
			end
		end else if (end_sum < {1'b0, item.stop_offset}) begin
			in_place = 1'b1;
		end else begin
			rsv_status = ST_FULL;
		end

		// in-place grants of more than a few words need consumer support
		if (in_place && !(cfg.reserve_capable || item.byte_count <= OFS_W'(SMALL_GRANT))) begin
			rsv_status = ST_BOUNCE;
		end

		// commit: advance with a single wrap
		commit_bytes = (item.operation == OP_COMMIT) ? item.byte_count : cur.pending_size;
		commit_sum   = {1'b0, cur.next_write} + {1'b0, commit_bytes};
		wrapped      = commit_sum[OFS_W-1:0];
		if (commit_sum >= {1'b0, cfg.ring_end}) begin
			wrapped = commit_sum[OFS_W-1:0] - (cfg.ring_end - cfg.ring_start);
		end

		case (item.operation)
			OP_RESERVE: begin
				res.status = rsv_status;
				if (rsv_status == ST_OK) begin
					nxt.pending_size = item.byte_count;
					res.area_offset  = cur.next_write;
					res.mark_write   = cfg.reserve_capable;
					res.mark_value   = cfg.reserve_capable ? item.byte_count : '0;
				end
			end
			OP_COMMIT, OP_COMMIT_STORED: begin
				if (cur.pending_size == '0) begin
					res.status = ST_NONE;
				end else begin
					res.status       = ST_OK;
					nxt.pending_size = '0;
					nxt.next_write   = wrapped;
					res.mark_write   = cfg.reserve_capable;
				end
			end
			default: res.status = ST_OK;
		endcase

		res.write_pointer = nxt.next_write;
	end

endmodule
